FILE: rtl/pcdt_pkg.sv
// Shared types and constants for the per-cpu call depth tracker.
`timescale 1ns / 1ps
package pcdt_pkg;

  localparam int unsigned CPU_IN_W    = 3;   // width of the cpu field
  localparam int unsigned PORT_ID_W   = 32;  // width of the id fields at the ports
  localparam int unsigned DEPTH_OUT_W = 6;   // width of the reported depth

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_COUNT = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_WR0   = 7'b0010000,
    S_WR1   = 7'b0100000,
    S_DONE  = 7'b1000000
  } pcdt_state_e;

  // Result of one event, handed from the sequencer to the output register.
  typedef struct packed {
    logic [DEPTH_OUT_W-1:0] depth;
    logic                   write_dropped;
  } pcdt_res_t;

endpackage

FILE: rtl/pcdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pcdt_seq.sv
// Scan sequencer: walks one cpu's stack through a single id comparator.
`timescale 1ns / 1ps
module pcdt_seq #(
  parameter int unsigned CPUS        = 8,
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned ID_BITS     = 32,
  localparam int unsigned CPU_W  = (CPUS > 1) ? $clog2(CPUS) : 1,
  localparam int unsigned SLOTS  = CPUS * STACK_DEPTH,
  localparam int unsigned SA_W   = $clog2(SLOTS),
  localparam int unsigned IDX_W  = $clog2(STACK_DEPTH),
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event in
  input  logic                          start_i,
  input  logic [pcdt_pkg::CPU_IN_W-1:0] cpu_i,
  input  logic [ID_BITS-1:0]            callee_id_i,
  input  logic                          callee_known_i,
  input  logic [ID_BITS-1:0]            caller_id_i,
  output logic                          busy_o,
  // result out
  output logic                          done_o,
  input  logic                          take_i,
  output pcdt_pkg::pcdt_res_t           res_o,
  // slot id store
  output logic [SA_W-1:0]               slot_raddr_o,
  input  logic [ID_BITS-1:0]            slot_rdata_i,
  output logic                          slot_we_o,
  output logic [SA_W-1:0]               slot_waddr_o,
  output logic [ID_BITS-1:0]            slot_wdata_o,
  // per-cpu fill count store
  output logic [CPU_W-1:0]              fill_raddr_o,
  input  logic [CNT_W-1:0]              fill_rdata_i,
  output logic                          fill_we_o,
  output logic [CPU_W-1:0]              fill_waddr_o,
  output logic [CNT_W-1:0]              fill_wdata_o
);

  pcdt_pkg::pcdt_state_e state_q, state_d;
  logic [CPUS-1:0]       fvld_q, fvld_d;

  logic [CPU_W-1:0]   cpu_q, cpu_d;
  logic               inrange_q, inrange_d;
  logic [ID_BITS-1:0] callee_q, callee_d;
  logic [ID_BITS-1:0] caller_q, caller_d;
  logic               known_q, known_d;
  logic [SA_W-1:0]    base_q, base_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [CNT_W-1:0]   nnew_q, nnew_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   wslot_q, wslot_d;
  logic [pcdt_pkg::DEPTH_OUT_W-1:0] depth_q, depth_d;
  logic               drop_q, drop_d;

  logic [CNT_W-1:0]   fill_cur;
  logic [CNT_W-1:0]   idx_p1;
  logic [CNT_W-1:0]   miss_min;
  logic               hit;

  assign fill_cur = fvld_q[cpu_q] ? fill_rdata_i : '0;
  assign idx_p1   = CNT_W'(idx_q) + CNT_W'(1);
  assign miss_min = known_q ? CNT_W'(2) : CNT_W'(1);
  assign hit      = (slot_rdata_i == caller_q);

  always_comb begin
    state_d   = state_q;
    fvld_d    = fvld_q;
    cpu_d     = cpu_q;
    inrange_d = inrange_q;
    callee_d  = callee_q;
    caller_d  = caller_q;
    known_d   = known_q;
    base_d    = base_q;
    n_d       = n_q;
    nnew_d    = nnew_q;
    idx_d     = idx_q;
    wslot_d   = wslot_q;
    depth_d   = depth_q;
    drop_d    = drop_q;

    slot_raddr_o = base_q;
    slot_we_o    = 1'b0;
    slot_waddr_o = base_q;
    slot_wdata_o = callee_q;
    fill_we_o    = 1'b0;

    unique case (state_q)
      pcdt_pkg::S_IDLE: begin
        if (start_i) begin
          cpu_d     = CPU_W'(cpu_i);
          inrange_d = (int'(cpu_i) < CPUS);
          callee_d  = callee_id_i;
          caller_d  = caller_id_i;
          known_d   = callee_known_i;
          depth_d   = '0;
          drop_d    = 1'b0;
          state_d   = (int'(cpu_i) < CPUS) ? pcdt_pkg::S_LOAD : pcdt_pkg::S_DONE;
        end
      end
      pcdt_pkg::S_LOAD: begin
        // fill count read is in flight; form the stack base meanwhile
        base_d  = SA_W'(int'(cpu_q) * STACK_DEPTH);
        state_d = pcdt_pkg::S_COUNT;
      end
      pcdt_pkg::S_COUNT: begin
        n_d          = fill_cur;
        idx_d        = '0;
        slot_raddr_o = base_q;
        if (fill_cur == '0) begin
          nnew_d  = miss_min;
          state_d = pcdt_pkg::S_WR0;
        end else begin
          state_d = pcdt_pkg::S_SCAN;
        end
      end
      pcdt_pkg::S_SCAN: begin
        // data for idx_q arrives now; fetch idx_q+1 in the same cycle
        if (idx_p1 < n_q) begin
          slot_raddr_o = base_q + SA_W'(idx_p1);
        end
        if (hit) begin
          depth_d = pcdt_pkg::DEPTH_OUT_W'(idx_q);
          nnew_d  = n_q;
          if (!known_q) begin
            state_d = pcdt_pkg::S_DONE;
          end else if (idx_p1 == CNT_W'(STACK_DEPTH)) begin
            drop_d  = 1'b1;
            state_d = pcdt_pkg::S_DONE;
          end else begin
            wslot_d = IDX_W'(idx_p1);
            if (idx_p1 == n_q) begin
              nnew_d = n_q + CNT_W'(1);
            end
            state_d = pcdt_pkg::S_WR1;
          end
        end else if (idx_p1 == n_q) begin
          // caller not on the stack: restart it at the bottom
          depth_d = '0;
          nnew_d  = (n_q > miss_min) ? n_q : miss_min;
          state_d = pcdt_pkg::S_WR0;
        end else begin
          idx_d = IDX_W'(idx_p1);
        end
      end
      pcdt_pkg::S_WR0: begin
        slot_we_o    = 1'b1;
        slot_waddr_o = base_q;
        slot_wdata_o = caller_q;
        wslot_d      = IDX_W'(1);
        state_d      = known_q ? pcdt_pkg::S_WR1 : pcdt_pkg::S_DONE;
      end
      pcdt_pkg::S_WR1: begin
        slot_we_o    = 1'b1;
        slot_waddr_o = base_q + SA_W'(wslot_q);
        slot_wdata_o = callee_q;
        state_d      = pcdt_pkg::S_DONE;
      end
      pcdt_pkg::S_DONE: begin
        if (take_i) begin
          if (inrange_q) begin
            fill_we_o      = 1'b1;
            fvld_d[cpu_q]  = 1'b1;
          end
          state_d = pcdt_pkg::S_IDLE;
        end
      end
      default: state_d = pcdt_pkg::S_IDLE;
    endcase
  end

  assign fill_raddr_o      = cpu_q;
  assign fill_waddr_o      = cpu_q;
  assign fill_wdata_o      = nnew_q;
  assign busy_o            = (state_q != pcdt_pkg::S_IDLE);
  assign done_o            = (state_q == pcdt_pkg::S_DONE);
  assign res_o.depth         = depth_q;
  assign res_o.write_dropped = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcdt_pkg::S_IDLE;
      fvld_q  <= '0;
    end else begin
      state_q <= state_d;
      fvld_q  <= fvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpu_q     <= cpu_d;
    inrange_q <= inrange_d;
    callee_q  <= callee_d;
    caller_q  <= caller_d;
    known_q   <= known_d;
    base_q    <= base_d;
    n_q       <= n_d;
    nnew_q    <= nnew_d;
    idx_q     <= idx_d;
    wslot_q   <= wslot_d;
    depth_q   <= depth_d;
    drop_q    <= drop_d;
  end

endmodule

FILE: rtl/per_cpu_call_depth_tracker_top.sv
// Top level of the per-cpu call depth tracker: stores, sequencer, output register.
`timescale 1ns / 1ps
// Each input transaction is one function-entry event (cpu, callee id, callee-known flag,
// caller id). The block keeps one stack of function ids per cpu and searches that cpu's
// stack from slot 0 up to its last occupied slot for the caller. On a hit at slot i the
// callee goes to slot i+1 and depth i is returned; with a known callee, a hit in the top
// slot drops the callee write and raises write_dropped. On a miss the caller goes to
// slot 0, the callee to slot 1, and depth 0 is returned. An unknown callee is never
// stored, and an event for a cpu at or above CPUS leaves the stacks alone and returns
// zeros. Exactly one output transaction follows each input transaction. Occupied slots
// always form a prefix, so each cpu carries a fill count (in a small RAM, flagged valid
// per cpu) instead of a valid bit per slot; no clearing pass is needed after reset. An
// event passes through the sequencer states load, count, scan over k slots (0 for an
// empty stack, up to STACK_DEPTH, one slot per cycle through the single id comparator
// reading the slot RAM), then w slot writes (0 to 2) and done; an event for an
// out-of-range cpu goes straight to done. The input is stalled while an event is in
// flight; the finished result sits in an output register, so a stalled output only
// holds the block once a second result is ready.
module per_cpu_call_depth_tracker_top #(
  parameter int unsigned CPUS        = 8,
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned ID_BITS     = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // event input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pcdt_pkg::CPU_IN_W-1:0]        cpu_i,
  input  logic [pcdt_pkg::PORT_ID_W-1:0]       callee_id_i,
  input  logic                                 callee_known_i,
  input  logic [pcdt_pkg::PORT_ID_W-1:0]       caller_id_i,
  // result output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pcdt_pkg::DEPTH_OUT_W-1:0]     depth_o,
  output logic                                 write_dropped_o
);

  localparam int unsigned CPU_W = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned SLOTS = CPUS * STACK_DEPTH;
  localparam int unsigned SA_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic                busy;
  logic                start;
  logic                done;
  logic                take;
  pcdt_pkg::pcdt_res_t res;

  logic [SA_W-1:0]    slot_raddr;
  logic [ID_BITS-1:0] slot_rdata;
  logic               slot_we;
  logic [SA_W-1:0]    slot_waddr;
  logic [ID_BITS-1:0] slot_wdata;
  logic [CPU_W-1:0]   fill_raddr;
  logic [CNT_W-1:0]   fill_rdata;
  logic               fill_we;
  logic [CPU_W-1:0]   fill_waddr;
  logic [CNT_W-1:0]   fill_wdata;

  logic                              out_valid_q, out_valid_d;
  logic [pcdt_pkg::DEPTH_OUT_W-1:0]  depth_q;
  logic                              drop_q;

  // one event in flight at a time
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;

  // result moves to the output register when it is empty or being drained
  assign take = done && (!out_valid_q || !out_stall_i);

  pcdt_seq #(
    .CPUS        (CPUS),
    .STACK_DEPTH (STACK_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cpu_i          (cpu_i),
    .callee_id_i    (ID_BITS'(callee_id_i)),
    .callee_known_i (callee_known_i),
    .caller_id_i    (ID_BITS'(caller_id_i)),
    .busy_o         (busy),
    .done_o         (done),
    .take_i         (take),
    .res_o          (res),
    .slot_raddr_o   (slot_raddr),
    .slot_rdata_i   (slot_rdata),
    .slot_we_o      (slot_we),
    .slot_waddr_o   (slot_waddr),
    .slot_wdata_o   (slot_wdata),
    .fill_raddr_o   (fill_raddr),
    .fill_rdata_i   (fill_rdata),
    .fill_we_o      (fill_we),
    .fill_waddr_o   (fill_waddr),
    .fill_wdata_o   (fill_wdata)
  );

  // function ids of all stacks, cpu-major
  pcdt_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // occupied-slot count per cpu
  pcdt_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CPUS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      depth_q <= res.depth;
      drop_q  <= res.write_dropped;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign depth_o         = depth_q;
  assign write_dropped_o = drop_q;

endmodule
